// ===== sv/dst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the deadline slot table.
package dst_pkg;

	localparam int SLOTS_DEF = 16;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_POP,
		S_DONE
	} dst_state_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [9:0]         room_tag;
		logic [15:0]        text_id;
		logic signed [7:0]  delta;
		logic [15:0]        deadline_minutes;
		logic [15:0]        time_now;
	} dst_req_t;

	typedef struct packed {
		logic               success;
		logic [9:0]         out_room;
		logic [15:0]        out_text;
		logic signed [7:0]  out_delta;
		logic [15:0]        out_deadline;
	} dst_rsp_t;

	typedef struct packed {
		logic [9:0]         room;
		logic [15:0]        text;
		logic signed [7:0]  delta;
		logic [15:0]        deadline;
	} dst_entry_t;

endpackage

// ===== sv/dst_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/deadline_slot_table.sv =====
`timescale 1ns / 1ps
// Deadline slot table: top level with scan sequencer, slot flags and entry RAM.
//
// Holds SLOTS timed entries. Entry payloads live in a one-port-read RAM; the
// per-slot active flags and the high-water count sit in flops and reset clear.
// One request is worked on at a time. An add walks the slots one per cycle
// until it finds a free one, or up to the last slot when the table is full.
// A pop streams slot reads through the RAM one per cycle, each compare in the
// cycle after its read, until a due entry is hit or the reads reach the
// high-water count. Clear and the unused opcode go straight to the done state.
// The finished result goes to an output register, so the next request is taken
// while it waits for transfer; a request that finishes while the previous
// result is still stalled waits in its last state.
module deadline_slot_table #(
	parameter int SLOTS = dst_pkg::SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  dst_pkg::dst_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dst_pkg::dst_rsp_t rsp
);

	import dst_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int ENT_W = $bits(dst_entry_t);

	dst_state_t         state_q, state_d;
	dst_req_t           cmd_q;
	dst_rsp_t           res_q, rsp_q;
	logic [CNT_W-1:0]   scan_q;
	logic [CNT_W-1:0]   hw_q;
	logic [SLOTS-1:0]   active_q;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               rsp_valid_q;

	logic               accept;
	logic [IDX_W-1:0]   scan_idx;
	logic               add_free, add_last;
	logic               issue, pop_hit, pop_end, out_free;
	logic               ram_we;
	logic [ENT_W-1:0]   ram_wdata, ram_rdata;
	dst_entry_t         wr_entry, rd_entry;

	assign accept   = req_valid && !req_stall;
	assign scan_idx = scan_q[IDX_W-1:0];
	assign add_free = !active_q[scan_idx];
	assign add_last = (scan_q == CNT_W'(SLOTS - 1));
	assign rd_entry = dst_entry_t'(ram_rdata);
	assign pop_hit  = valid_s1 && active_q[idx_s1]
		&& (rd_entry.deadline <= cmd_q.time_now);
	assign pop_end  = !valid_s1 && (scan_q >= hw_q);
	assign issue    = (state_q == S_POP) && (scan_q < hw_q) && !pop_hit;
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign wr_entry.room     = cmd_q.room_tag;
	assign wr_entry.text     = cmd_q.text_id;
	assign wr_entry.delta    = cmd_q.delta;
	assign wr_entry.deadline = cmd_q.deadline_minutes;
	assign ram_wdata         = ENT_W'(wr_entry);

	dst_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOTS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (scan_idx),
		.wdata (ram_wdata),
		.raddr (scan_idx),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.opcode == OP_ADD) begin
						state_d = S_ADD;
					end else if (req.opcode == OP_POP) begin
						state_d = S_POP;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_ADD: begin
				if (add_free || add_last) begin
					state_d = S_DONE;
				end
			end
			S_POP: begin
				if (pop_hit || pop_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall = (state_q != S_IDLE);
		ram_we    = (state_q == S_ADD) && add_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			hw_q        <= '0;
			active_q    <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (accept) begin
				scan_q <= '0;
				if (req.opcode == OP_CLEAR) begin
					active_q <= '0;
					hw_q     <= '0;
				end
			end
			if (state_q == S_ADD) begin
				if (add_free) begin
					active_q[scan_idx] <= 1'b1;
					if (scan_q >= hw_q) begin
						hw_q <= scan_q + CNT_W'(1);
					end
				end else if (!add_last) begin
					scan_q <= scan_q + CNT_W'(1);
				end
			end
			if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (state_q == S_POP && pop_hit) begin
				active_q[idx_s1] <= 1'b0;
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx;
		if (accept) begin
			cmd_q <= req;
			res_q <= '0;
		end
		if (state_q == S_ADD && add_free) begin
			res_q.success <= 1'b1;
		end
		if (state_q == S_POP && pop_hit) begin
			res_q.success      <= 1'b1;
			res_q.out_room     <= rd_entry.room;
			res_q.out_text     <= rd_entry.text;
			res_q.out_delta    <= rd_entry.delta;
			res_q.out_deadline <= rd_entry.deadline;
		end
		if (state_q == S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// no active slot at or above the high-water mark
	assert property (@(posedge clk) disable iff (!arst_n)
		(active_q >> hw_q) == '0)
		else $error("active slot above high-water mark");

	assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= CNT_W'(SLOTS))
		else $error("high-water count exceeds slot count");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.opcode == OP_CLEAR |=> active_q == '0 && hw_q == '0)
		else $error("clear left state behind");

	// pipelined compare only looks at slots below the mark
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q == S_POP && CNT_W'(idx_s1) < hw_q)
		else $error("pop compare outside scan range");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> req_stall && !active_q[scan_idx])
		else $error("entry write into an occupied slot");

endmodule
